### rtl/qppt_pkg.sv
// shared types and constants of the qualified pulse period timer
// used by qppt_step and qualified_pulse_period_timer; no dependencies
`default_nettype none

package qppt_pkg;

   // channel field width fixes the channel count
   localparam int CH_W       = 4;
   localparam int CHANNELS   = 2 ** CH_W;
   // qualifier bytes present on every transaction, and how many are tracked
   localparam int QUAL_INPUTS = 3;
   localparam int QUALIFIERS  = 3;
   localparam int TICK_W      = 32;
   localparam int LEVEL_W     = 8;
   localparam int COUNT_W     = 3;
   localparam int QUAL_W      = 8;

   typedef struct packed {
      logic [CH_W-1:0]                     channel;
      logic [TICK_W-1:0]                   tick;
      logic [LEVEL_W-1:0]                  pulse_level;
      logic [COUNT_W-1:0]                  qualifier_count;
      logic [QUAL_INPUTS-1:0][QUAL_W-1:0]  qualifier;
   } item_type;

   typedef struct packed {
      logic [TICK_W-1:0]                   start_tick;
      logic [TICK_W-1:0]                   held_period;
      logic                                armed;
      logic                                low_seen;
      logic [QUALIFIERS-1:0][QUAL_W-1:0]   q_last;
      logic [QUALIFIERS-1:0]               q_changed;
   } chan_state_type;

   typedef struct packed {
      logic [TICK_W-1:0]                   period;
      logic                                fresh;
   } result_type;

endpackage

`default_nettype wire

### rtl/qppt_step.sv
// per-transaction update of one channel's timer state
// depends on qppt_pkg
`default_nettype none

module qppt_step (
   input  qppt_pkg::item_type       item,
   input  qppt_pkg::chan_state_type cur,
   output qppt_pkg::chan_state_type nxt,
   output qppt_pkg::result_type     res
);

   logic [qppt_pkg::COUNT_W-1:0]    count_m1;
   logic [qppt_pkg::COUNT_W-1:0]    active;
   logic [qppt_pkg::QUALIFIERS-1:0] q_en;
   logic [qppt_pkg::QUALIFIERS-1:0] q_chg;
   logic [qppt_pkg::QUALIFIERS-1:0] q_ok;
   logic                            count_ok;
   logic                            all_ok;
   logic                            high;

   // active qualifiers: count minus one, saturated
   always_comb begin
      count_m1 = item.qualifier_count - qppt_pkg::COUNT_W'(1);
      if (item.qualifier_count == '0) begin
         active = '0;
      end else if (count_m1 > qppt_pkg::COUNT_W'(qppt_pkg::QUALIFIERS)) begin
         active = qppt_pkg::COUNT_W'(qppt_pkg::QUALIFIERS);
      end else begin
         active = count_m1;
      end
      count_ok = (item.qualifier_count != '0) &&
                 (item.qualifier_count <= qppt_pkg::COUNT_W'(qppt_pkg::QUALIFIERS + 1));
   end

   always_comb begin
      for (int i = 0; i < qppt_pkg::QUALIFIERS; i++) begin
         q_en[i]  = (qppt_pkg::COUNT_W'(i) < active);
         q_chg[i] = cur.q_changed[i] |
                    (q_en[i] && (item.qualifier[i] != '0) &&
                     (item.qualifier[i] != cur.q_last[i]));
         q_ok[i]  = !q_en[i] || q_chg[i];
      end
      all_ok = count_ok && (&q_ok);
      high   = |item.pulse_level;
   end

   always_comb begin
      nxt       = cur;
      res.fresh = 1'b0;
      for (int i = 0; i < qppt_pkg::QUALIFIERS; i++) begin
         if (q_en[i]) begin
            nxt.q_last[i] = item.qualifier[i];
         end
      end
      nxt.q_changed = q_chg;
      if (high) begin
         if (!cur.armed && cur.low_seen) begin
            // arming edge: latch start, flags kept
            nxt.start_tick = item.tick;
            nxt.armed      = 1'b1;
            nxt.low_seen   = 1'b0;
         end else if (cur.low_seen) begin
            if (all_ok) begin
               nxt.held_period = item.tick - cur.start_tick;
               nxt.start_tick  = item.tick;
               res.fresh       = 1'b1;
            end
            nxt.q_changed = q_chg & ~q_en;
            nxt.low_seen  = 1'b0;
         end
      end else begin
         nxt.low_seen = 1'b1;
      end
      res.period = nxt.held_period;
   end

endmodule

`default_nettype wire

### rtl/qualified_pulse_period_timer.sv
// top level of the qualified pulse period timer: input register, channel
// state flops and result register; depends on qppt_pkg and qppt_step
`default_nettype none

// channel   direction  handshake             payload
// req_      in         req_valid/req_stall   channel, tick, pulse_level,
//                                            qualifier_count, qualifier_a..c
// rsp_      out        rsp_valid/rsp_stall   period, new_period
//
// one transaction per cycle sustained while rsp_stall stays low; a transaction
// is captured in the input register when accepted, and its result is then
// written to the result register, from which it can be taken
// the channel state read-modify-write sits in one stage, so back-to-back
// transactions on the same channel see each other's updates without bypass
// synchronous reset clears all channel state at once; no clearing pass
// a stalled result holds the result register; the input register keeps
// accepting until it too is full, then req_stall rises

module qualified_pulse_period_timer (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output      logic                           req_stall,
   input  wire logic [qppt_pkg::CH_W-1:0]      req_channel,
   input  wire logic [qppt_pkg::TICK_W-1:0]    req_tick,
   input  wire logic [qppt_pkg::LEVEL_W-1:0]   req_pulse_level,
   input  wire logic [qppt_pkg::COUNT_W-1:0]   req_qualifier_count,
   input  wire logic [qppt_pkg::QUAL_W-1:0]    req_qualifier_a,
   input  wire logic [qppt_pkg::QUAL_W-1:0]    req_qualifier_b,
   input  wire logic [qppt_pkg::QUAL_W-1:0]    req_qualifier_c,
   output      logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   output      logic [qppt_pkg::TICK_W-1:0]    rsp_period,
   output      logic                           rsp_new_period
);

   // input register
   logic                     s1_valid_ff, s1_valid_in;
   qppt_pkg::item_type       s1_item_ff;
   qppt_pkg::item_type       req_item;

   // result register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [qppt_pkg::TICK_W-1:0] rsp_period_ff;
   logic                     rsp_new_period_ff;

   // per-channel state, every channel code addresses a channel
   qppt_pkg::chan_state_type chan_ff [qppt_pkg::CHANNELS];
   qppt_pkg::chan_state_type chan_rd;
   qppt_pkg::chan_state_type chan_in;
   qppt_pkg::result_type     step_res;
   logic [qppt_pkg::CHANNELS-1:0] armed_vec;

   logic                     accept;
   logic                     s2_free;
   logic                     move;

   // pack the incoming fields
   always_comb begin
      req_item.channel         = req_channel;
      req_item.tick            = req_tick;
      req_item.pulse_level     = req_pulse_level;
      req_item.qualifier_count = req_qualifier_count;
      req_item.qualifier[0]    = req_qualifier_a;
      req_item.qualifier[1]    = req_qualifier_b;
      req_item.qualifier[2]    = req_qualifier_c;
   end

   // flow control: result slot frees when empty or being taken
   assign s2_free   = !rsp_valid_ff || !rsp_stall;
   assign move      = s1_valid_ff && s2_free;
   assign req_stall = s1_valid_ff && !s2_free;
   assign accept    = req_valid && !req_stall;

   assign s1_valid_in  = accept || (s1_valid_ff && !move);
   assign rsp_valid_in = move || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= req_item;
      end
      if (move) begin
         rsp_period_ff     <= step_res.period;
         rsp_new_period_ff <= step_res.fresh;
      end
   end

   // state of the channel in the input register
   assign chan_rd = chan_ff[s1_item_ff.channel];

   qppt_step u_step (
      .item (s1_item_ff),
      .cur  (chan_rd),
      .nxt  (chan_in),
      .res  (step_res)
   );

   // write back the updated channel state as the transaction moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < qppt_pkg::CHANNELS; i++) begin
            chan_ff[i] <= '0;
         end
      end else if (move) begin
         chan_ff[s1_item_ff.channel] <= chan_in;
      end
   end

   always_comb begin
      for (int i = 0; i < qppt_pkg::CHANNELS; i++) begin
         armed_vec[i] = chan_ff[i].armed;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_period     = rsp_period_ff;
   assign rsp_new_period = rsp_new_period_ff;

   // a fresh period only comes from an armed channel
   a_fresh_needs_armed: assert property (@(posedge clock) disable iff (reset)
      move && step_res.fresh |-> chan_rd.armed)
      else $error("fresh period on an unarmed channel");

   // once armed, a channel stays armed
   a_armed_sticky: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ((armed_vec & $past(armed_vec)) == $past(armed_vec)))
      else $error("armed flag dropped");

   // the result register's period matches the stored held period
   a_held_matches: assert property (@(posedge clock) disable iff (reset)
      move |=> chan_ff[$past(s1_item_ff.channel)].held_period == rsp_period_ff)
      else $error("result period differs from held period");

   // a blocked input register keeps its transaction
   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_free |=> s1_valid_ff && $stable(s1_item_ff))
      else $error("input register lost a blocked transaction");

endmodule

`default_nettype wire

### tb/period_scoreboard_pkg.sv
// scoreboard for the qualified pulse period timer: per-channel period predictor
// and the queue of expected results; depends on qppt_pkg
`timescale 1ns / 1ps

package period_scoreboard_pkg;

   import qppt_pkg::*;

   class period_scoreboard;

      bit [TICK_W-1:0] start_tick   [CHANNELS];
      bit [TICK_W-1:0] held_period  [CHANNELS];
      bit              armed        [CHANNELS];
      bit              low_seen     [CHANNELS];
      bit [QUAL_W-1:0] qual_last    [CHANNELS][QUALIFIERS];
      bit              qual_changed [CHANNELS][QUALIFIERS];
      result_type      expected_results[$];
      int              errors;

      function int pending();
         return expected_results.size();
      endfunction

      // advance the channel state by one accepted transaction and queue its result
      function void note_request(item_type it);
         int unsigned ch;
         int unsigned active;
         int          i;
         bit          all_set;
         result_type  r;
         ch = it.channel;
         r.fresh = 1'b0;
         active = (it.qualifier_count == 0) ? 0 : it.qualifier_count - 1;
         if (active > QUALIFIERS)
            active = QUALIFIERS;
         for (i = 0; i < active; i++) begin
            if (it.qualifier[i] != 0 && it.qualifier[i] != qual_last[ch][i])
               qual_changed[ch][i] = 1'b1;
            qual_last[ch][i] = it.qualifier[i];
         end
         if (it.pulse_level != 0) begin
            if (!armed[ch] && low_seen[ch]) begin
               start_tick[ch] = it.tick;
               armed[ch] = 1'b1;
               low_seen[ch] = 1'b0;
            end else if (low_seen[ch]) begin
               // counted edge: emit only for a count of one to QUALIFIERS + 1 and when every tracked qualifier moved
               all_set = (it.qualifier_count >= 1 && it.qualifier_count <= QUALIFIERS + 1);
               for (i = 0; i < active; i++)
                  if (!qual_changed[ch][i])
                     all_set = 1'b0;
               if (all_set) begin
                  held_period[ch] = it.tick - start_tick[ch];
                  start_tick[ch] = it.tick;
                  r.fresh = 1'b1;
               end
               for (i = 0; i < active; i++)
                  qual_changed[ch][i] = 1'b0;
               low_seen[ch] = 1'b0;
            end
         end else begin
            low_seen[ch] = 1'b1;
         end
         r.period = held_period[ch];
         expected_results.push_back(r);
      endfunction

      function void check_result(logic [TICK_W-1:0] period, logic new_period);
         result_type r;
         if (expected_results.size() == 0) begin
            $error("unexpected result: period %0h new_period %0b", period, new_period);
            errors++;
            return;
         end
         r = expected_results.pop_front();
         if (period !== r.period) begin
            $error("period: expected %0h, got %0h", r.period, period);
            errors++;
         end
         if (new_period !== r.fresh) begin
            $error("new_period: expected %0b, got %0b", r.fresh, new_period);
            errors++;
         end
      endfunction

   endclass

endpackage

### tb/tb_qualified_pulse_period_timer.sv
// testbench for qualified_pulse_period_timer: directed edge cases, then random
// pulse sequences with random idling on both channels; depends on qppt_pkg
// and period_scoreboard_pkg
`timescale 1ns / 1ps

module tb_qualified_pulse_period_timer;

   import qppt_pkg::*;
   import period_scoreboard_pkg::*;

   localparam int RANDOM_ITEMS   = 2000;
   // longest legal silence is a sender gap plus a receiver stall plus the
   // pipeline, far below this
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 8;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [CH_W-1:0]     req_channel = '0;
   logic [TICK_W-1:0]   req_tick = '0;
   logic [LEVEL_W-1:0]  req_pulse_level = '0;
   logic [COUNT_W-1:0]  req_qualifier_count = '0;
   logic [QUAL_W-1:0]   req_qualifier_a = '0;
   logic [QUAL_W-1:0]   req_qualifier_b = '0;
   logic [QUAL_W-1:0]   req_qualifier_c = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [TICK_W-1:0]   rsp_period;
   logic                rsp_new_period;

   period_scoreboard    sb;
   int                  idle_cycles = 0;
   int                  send_calm = 0;
   int                  recv_calm = 0;
   bit [TICK_W-1:0]     tick_now = 32'hFFFF_0000;   // wraps early in the random part

   always #6 clock = ~clock;

   qualified_pulse_period_timer u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_channel         (req_channel),
      .req_tick            (req_tick),
      .req_pulse_level     (req_pulse_level),
      .req_qualifier_count (req_qualifier_count),
      .req_qualifier_a     (req_qualifier_a),
      .req_qualifier_b     (req_qualifier_b),
      .req_qualifier_c     (req_qualifier_c),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_period          (rsp_period),
      .rsp_new_period      (rsp_new_period)
   );

   // wait before the next transaction: mostly random, with calm stretches of
   // back-to-back traffic now and then
   function automatic int draw_wait(ref int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         calm_left = $urandom_range(20, 60);
         return 0;
      end
      return $urandom_range(0, 15);
   endfunction

   function automatic item_type make_item(int ch, bit [TICK_W-1:0] tk, int level, int cnt,
                                          int qa, int qb, int qc);
      item_type it;
      it.channel         = CH_W'(ch);
      it.tick            = tk;
      it.pulse_level     = LEVEL_W'(level);
      it.qualifier_count = COUNT_W'(cnt);
      it.qualifier[0]    = QUAL_W'(qa);
      it.qualifier[1]    = QUAL_W'(qb);
      it.qualifier[2]    = QUAL_W'(qc);
      return it;
   endfunction

   // running tick with the odd jump to an arbitrary value
   function automatic bit [TICK_W-1:0] next_tick();
      if ($urandom_range(0, 19) == 0)
         tick_now = $urandom;
      else
         tick_now = tick_now + $urandom_range(1, 600);
      return tick_now;
   endfunction

   // qualifier value: zeros, small values that repeat, or anything
   function automatic int pick_qual(bit force_change);
      if (force_change)
         return $urandom_range(1, 255);
      case ($urandom_range(0, 9))
         0, 1:       return 0;
         2, 3, 4, 5: return $urandom_range(1, 2);
         default:    return $urandom_range(0, 255);
      endcase
   endfunction

   // present one transaction and hold it until accepted
   task automatic send_item(input item_type it);
      int gap;
      gap = draw_wait(send_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_channel         <= it.channel;
      req_tick            <= it.tick;
      req_pulse_level     <= it.pulse_level;
      req_qualifier_count <= it.qualifier_count;
      req_qualifier_a     <= it.qualifier[0];
      req_qualifier_b     <= it.qualifier[1];
      req_qualifier_c     <= it.qualifier[2];
      req_valid           <= 1'b1;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   // stop sending and wait until every queued result has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   // a short run of lows, then a rising edge, all on one channel
   task automatic send_pulse_burst(inout int sent);
      int ch;
      int cnt;
      int lows;
      int k;
      ch = $urandom_range(0, CHANNELS - 1);
      // mostly zero to three tracked qualifiers, sometimes a count of zero or too large
      cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 8) % 8 : $urandom_range(1, 4);
      lows = $urandom_range(1, 3);
      for (k = 0; k < lows; k++) begin
         send_item(make_item(ch, next_tick(), 0, cnt,
                             pick_qual($urandom_range(0, 9) < 6),
                             pick_qual($urandom_range(0, 9) < 6),
                             pick_qual($urandom_range(0, 9) < 6)));
         sent++;
      end
      send_item(make_item(ch, next_tick(), $urandom_range(1, 255), cnt,
                          pick_qual(1'b0), pick_qual(1'b0), pick_qual(1'b0)));
      sent++;
   endtask

   // transaction monitor, scoreboard hookup and stall watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_request(make_item(req_channel, req_tick, req_pulse_level,
                                      req_qualifier_count, req_qualifier_a,
                                      req_qualifier_b, req_qualifier_c));
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_period, rsp_new_period);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // result side: random stalls per transaction
   initial begin
      int hold;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         hold = draw_wait(recv_calm);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   initial begin
      int  sent;
      bit  paused;
      sent = 0;
      paused = 1'b0;
      sb = new;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // rising edge with no low before it is ignored
      send_item(make_item(0, 10, 1, 4, 0, 0, 0));
      // arm, then a counted edge with all three qualifiers moved
      send_item(make_item(0, 20, 0, 4, 1, 1, 1));
      send_item(make_item(0, 100, 8'h80, 4, 1, 1, 1));
      send_item(make_item(0, 150, 0, 4, 2, 2, 2));
      send_item(make_item(0, 350, 8'h01, 4, 2, 2, 2));
      // qualifiers unchanged: counted edge clears flags without a period
      send_item(make_item(0, 400, 0, 4, 2, 2, 2));
      send_item(make_item(0, 500, 8'hFF, 4, 2, 2, 2));
      send_item(make_item(0, 510, 8'h40, 4, 2, 2, 2));
      // count of zero never emits
      send_item(make_item(1, 0, 0, 0, 5, 6, 7));
      send_item(make_item(1, 5, 1, 0, 5, 6, 7));
      send_item(make_item(1, 50, 0, 0, 8, 9, 10));
      send_item(make_item(1, 100, 1, 0, 11, 12, 13));
      // count above the tracked qualifiers never emits
      send_item(make_item(2, 200, 0, 7, 3, 4, 5));
      send_item(make_item(2, 210, 2, 7, 3, 4, 5));
      send_item(make_item(2, 220, 0, 7, 6, 7, 8));
      send_item(make_item(2, 230, 2, 7, 9, 10, 11));
      // no qualifiers in use, period across the tick wrap
      send_item(make_item(3, 32'hFFFF_FFE0, 0, 1, 0, 0, 0));
      send_item(make_item(3, 32'hFFFF_FFF0, 4, 1, 0, 0, 0));
      send_item(make_item(3, 32'h0000_0004, 0, 1, 0, 0, 0));
      send_item(make_item(3, 32'h0000_0010, 4, 1, 0, 0, 0));
      // extremes on the top channel, zero qualifier keeps an earlier flag
      send_item(make_item(15, 32'hFFFF_FFFF, 0, 2, 8'hFF, 8'hFF, 8'hFF));
      send_item(make_item(15, 32'h0000_0000, 8'hFF, 2, 8'hFF, 8'hFF, 8'hFF));
      send_item(make_item(15, 32'h0000_0001, 0, 2, 0, 8'hAA, 8'h55));
      send_item(make_item(15, 32'hFFFF_FFFF, 8'h01, 2, 0, 8'h55, 8'hAA));
      wait_drained();

      // mostly well-formed pulse trains, the rest arbitrary transactions
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) < 8) begin
            send_pulse_burst(sent);
         end else begin
            send_item(make_item($urandom_range(0, CHANNELS - 1), $urandom,
                                $urandom_range(0, 255), $urandom_range(0, 7),
                                $urandom_range(0, 255), $urandom_range(0, 255),
                                $urandom_range(0, 255)));
            sent++;
         end
         if (!paused && sent >= RANDOM_ITEMS / 2) begin
            wait_drained();
            paused = 1'b1;
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.pending() != 0) begin
         $error("%0d expected results never arrived", sb.pending());
         sb.errors++;
      end
      if (sb.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
